@@ src/sidt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidt_pkg: shared types and constants for the scaled integer to text block
// Character codes, digit count and the queue head record.
// ----------------------------------------------------------------------------
package sidt_pkg;

   // Decimal digits held after conversion; covers 2**128 and a scale of 38.
   localparam int DIGITS      = 39;
   localparam int BCD_W       = DIGITS * 4;
   localparam int SCALE_W     = 6;
   localparam int SCALE_MAX   = 38;
   localparam int PTR_W       = 6;
   localparam int CHAR_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJ     = 4'd3;

   // Head of the request queue as seen by the back end.
   typedef struct packed {
      logic valid;
      logic neg;
   } head_type;

endpackage
`default_nettype wire

@@ src/sidt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidt_front: request intake
// Sign-extends the request, splits it into sign and magnitude and queues it.
// ----------------------------------------------------------------------------
module sidt_front #(
   parameter int VALUE_BITS = 128
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire signed [63:0]       req_value_high,
   input  wire        [63:0]       req_value_low,
   output sidt_pkg::head_type      q_head,
   output logic [VALUE_BITS-1:0]   q_mag,
   input  wire                     q_ready
);

   logic [127:0]            full_value;
   logic [VALUE_BITS-1:0]   trunc_value;
   logic                    neg;
   logic [VALUE_BITS-1:0]   mag;
   logic                    push;
   logic                    pop;

   logic [VALUE_BITS-1:0]   mag_ff [sidt_pkg::QUEUE_DEPTH];
   logic                    neg_ff [sidt_pkg::QUEUE_DEPTH];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [sidt_pkg::COUNT_W-1:0] count_ff, count_in;

   assign full_value  = {req_value_high, req_value_low};
   assign trunc_value = full_value[VALUE_BITS-1:0];
   assign neg         = trunc_value[VALUE_BITS-1];
   // Two's complement magnitude; the most negative value lands on 2**(n-1).
   assign mag = neg ? (~trunc_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : trunc_value;

   assign req_stall = (count_ff == sidt_pkg::COUNT_W'(sidt_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_head.valid && q_ready;

   assign q_head.valid = (count_ff != '0);
   assign q_head.neg   = neg_ff[rd_ptr_ff];
   assign q_mag        = mag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mag_ff[wr_ptr_ff] <= mag;
         neg_ff[wr_ptr_ff] <= neg;
      end
   end

endmodule
`default_nettype wire

@@ src/sidt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sidt_back: conversion and text emission
// Shift-and-add-3 binary to BCD, then a character sequencer into an
// output register.
// ----------------------------------------------------------------------------
module sidt_back #(
   parameter int VALUE_BITS = 128
) (
   input  wire                             clock,
   input  wire                             reset,
   input  sidt_pkg::head_type              q_head,
   input  wire [VALUE_BITS-1:0]            q_mag,
   output logic                            q_ready,
   input  wire [sidt_pkg::SCALE_W-1:0]     scale,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [sidt_pkg::CHAR_W-1:0]     rsp_text_char,
   output logic                            rsp_last_char
);

   localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_INT  = 3'd4;
   localparam logic [2:0] ST_DOT  = 3'd5;
   localparam logic [2:0] ST_FRAC = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic [VALUE_BITS-1:0]            mag_ff, mag_in;
   logic [sidt_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic                             neg_ff, neg_in;
   logic [sidt_pkg::PTR_W-1:0]       ptr_ff, ptr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sidt_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [sidt_pkg::DIGITS-1:0]      nz;
   logic [sidt_pkg::PTR_W-1:0]       top;
   logic [sidt_pkg::PTR_W-1:0]       start_ptr;
   logic [sidt_pkg::BCD_W-1:0]       adjusted;
   logic [sidt_pkg::BCD_W-1:0]       bcd_shift;
   logic [3:0]                       digit;
   logic [sidt_pkg::CHAR_W-1:0]      digit_char;
   logic                             lower_zero;
   logic                             out_free;
   logic                             emit;
   logic [sidt_pkg::CHAR_W-1:0]      emit_char;
   logic                             emit_last;

   // Per-digit nonzero flags, add-3 correction, most significant nonzero digit.
   always_comb begin
      logic [3:0] d;
      top = '0;
      for (int i = 0; i < sidt_pkg::DIGITS; i++) begin
         d = bcd_ff[4*i +: 4];
         nz[i] = (d != 4'd0);
         adjusted[4*i +: 4] = (d >= sidt_pkg::BCD_ADJ_MIN) ? (d + sidt_pkg::BCD_ADJ) : d;
         if (d != 4'd0) begin
            top = sidt_pkg::PTR_W'(i);
         end
      end
   end

   assign bcd_shift  = {adjusted[sidt_pkg::BCD_W-2:0], mag_ff[VALUE_BITS-1]};
   assign start_ptr  = (top > scale) ? top : scale;
   assign digit      = bcd_ff[{ptr_ff, 2'b00} +: 4];
   assign digit_char = sidt_pkg::CHAR_ZERO + {4'b0000, digit};
   // Nothing but zeros below the current fraction digit: it ends the text.
   assign lower_zero = ((nz & ((sidt_pkg::DIGITS'(1) << ptr_ff) - sidt_pkg::DIGITS'(1)))
                        == '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_ready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      neg_in    = neg_ff;
      ptr_in    = ptr_ff;
      emit      = 1'b0;
      emit_char = digit_char;
      emit_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               mag_in   = q_mag;
               neg_in   = q_head.neg;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = bcd_shift;
            mag_in  = {mag_ff[VALUE_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ptr_in   = start_ptr;
            state_in = neg_ff ? ST_SIGN : ST_INT;
         end
         ST_SIGN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = sidt_pkg::CHAR_MINUS;
               state_in  = ST_INT;
            end
         end
         ST_INT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = (ptr_ff == scale) && (scale == '0);
               if (ptr_ff == scale) begin
                  state_in = (scale == '0) ? ST_IDLE : ST_DOT;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         ST_DOT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = sidt_pkg::CHAR_DOT;
               ptr_in    = scale - 1'b1;
               state_in  = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = lower_zero;
               if (lower_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_char_in  = emit ? emit_char : rsp_char_ff;
   assign rsp_last_in  = emit ? emit_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule
`default_nettype wire

@@ src/scaled_integer_to_decimal_text.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_integer_to_decimal_text: signed scaled integer to ASCII decimal
// Turns a signed VALUE_BITS-bit integer and a decimal scale into text.
// ----------------------------------------------------------------------------
// Each request carries a signed integer as req_value_high:req_value_low; only
// the low VALUE_BITS bits count, sign-extended. csr_column_scale sets how many
// decimal digits sit after the point (values above 38 act as 38). The text
// leaves on the rsp_ channel one character per response, most significant
// first: an optional '-', the integer digits (a lone '0' if none), then, when
// the scale is nonzero, '.' and the fraction with trailing zeros dropped but
// at least one digit kept. rsp_last_char marks the final character. A front
// end takes requests into a two-entry queue, so up to two requests are taken
// while one converts. The back end loads a request, runs the shift-and-add-3
// conversion over all VALUE_BITS bits (one bit a cycle), finds the leading
// digit, then emits one character per cycle (1 to 41 characters) while the
// response side does not stall; it takes the next request only after the
// last character. Write the scale only while idle; the configuration port is
// always ready.
// ----------------------------------------------------------------------------
module scaled_integer_to_decimal_text #(
   parameter int VALUE_BITS = 128
) (
   input  wire                           clock,
   input  wire                           reset,
   // request channel
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire signed [63:0]             req_value_high,
   input  wire        [63:0]             req_value_low,
   // response channel
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [sidt_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                          rsp_last_char,
   // configuration
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [sidt_pkg::SCALE_W-1:0]   csr_column_scale
);

   sidt_pkg::head_type                q_head;
   logic [VALUE_BITS-1:0]             q_mag;
   logic                              q_ready;

   logic [sidt_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [sidt_pkg::SCALE_W-1:0]      scale_eff;

   // Scale register; the user must write it only between requests, the block does not enforce it.
   assign csr_ready = 1'b1;
   assign scale_in  = (csr_valid && csr_ready) ? csr_column_scale : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // Clamp so the text never exceeds 41 characters.
   assign scale_eff = (scale_ff > sidt_pkg::SCALE_W'(sidt_pkg::SCALE_MAX))
                      ? sidt_pkg::SCALE_W'(sidt_pkg::SCALE_MAX) : scale_ff;

   // Front end: sign/magnitude split and request queue.
   sidt_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_high (req_value_high),
      .req_value_low  (req_value_low),
      .q_head         (q_head),
      .q_mag          (q_mag),
      .q_ready        (q_ready)
   );

   // Back end: BCD conversion and character sequencer.
   sidt_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_mag         (q_mag),
      .q_ready       (q_ready),
      .scale         (scale_eff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

`ifndef SYNTHESIS
   // A full queue always presents a request to the back end.
   a_stall_has_head: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_head.valid)
      else $error("queue full with no head");

   // Once the back end takes a request it is busy on the next cycle.
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (q_head.valid && q_ready) |=> !q_ready)
      else $error("back end took a request but stayed idle");

   // Sign and point never end the text.
   a_punct_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_text_char == sidt_pkg::CHAR_MINUS ||
                     rsp_text_char == sidt_pkg::CHAR_DOT)) |-> !rsp_last_char)
      else $error("text ends on sign or point");

   // Only digits, sign and point leave the block.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_text_char >= sidt_pkg::CHAR_ZERO &&
                      rsp_text_char <= sidt_pkg::CHAR_ZERO + 8'd9) ||
                     rsp_text_char == sidt_pkg::CHAR_MINUS ||
                     rsp_text_char == sidt_pkg::CHAR_DOT))
      else $error("unexpected character");
`endif

endmodule
`default_nettype wire
